@@ rtl/sdw_pkg.sv @@
// ----------------------------------------------------------------------------
// sdw_pkg
// Field widths, word layout and register indexes of the square-to-disc warp.
// ----------------------------------------------------------------------------
package sdw_pkg;

  localparam int ROW_W      = 10;
  localparam int COL_W      = 10;
  localparam int PIX_W      = 8;
  localparam int CFG_W      = 11;
  localparam int CFG_ADDR_W = 1;
  localparam int TDATA_W    = 32;

  // tdata layout, lowest bit first
  localparam int ROW_LSB = 0;
  localparam int COL_LSB = ROW_LSB + ROW_W;
  localparam int PIX_LSB = COL_LSB + COL_W;
  localparam int PAD_W   = TDATA_W - PIX_LSB - PIX_W;

  localparam logic [CFG_W-1:0] RST_SIDE = CFG_W'(512);

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_IMAGE_HEIGHT = 1'b0,
    CFG_IMAGE_WIDTH  = 1'b1
  } cfg_reg_t;

endpackage

@@ rtl/square_to_disc_pixel_warp.sv @@
// ----------------------------------------------------------------------------
// square_to_disc_pixel_warp
// Elliptical grid forward warp: maps each source pixel position of a square
// image onto a disc and forwards the pixel value with its destination.
//
//   channel | dir | handshake         | content
//   in_     | in  | tvalid/tready     | src_row, src_col, pixel_in
//   out_    | out | tvalid/tready     | dest_row, dest_col, pixel_out
//   cfg_    | in  | we, no wait       | image_height (0), image_width (1)
//
// One word per cycle while the output is not stalled. The pipeline includes the
// per-bit divider (FRAC_BITS+2 stages) and square root (FRAC_BITS+1 stages)
// pipelines. Stages move independently: empty stages fill while the output
// is stalled, so nothing is lost or repeated.
// rst_n is synchronous; it empties the pipeline and sets both sides to 512.
// ----------------------------------------------------------------------------
module square_to_disc_pixel_warp #(
  parameter int MAX_SIDE  = 1024,
  parameter int FRAC_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // src_row[9:0], src_col[19:10], pixel_in[27:20], zero pad
  input  logic [sdw_pkg::TDATA_W-1:0]     in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // dest_row[9:0], dest_col[19:10], pixel_out[27:20], zero pad
  output logic [sdw_pkg::TDATA_W-1:0]     out_tdata,
  input  logic                            cfg_we,
  input  logic [sdw_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [sdw_pkg::CFG_W-1:0]       cfg_wdata
);
  import sdw_pkg::*;

  localparam int F    = FRAC_BITS;
  localparam int SW   = $clog2(MAX_SIDE + 1);
  localparam int HW   = (SW > CFG_W) ? SW : CFG_W;
  localparam int QW   = F + 2;
  localparam int RW   = HW + 1;
  localparam int SRW  = F + 5;
  localparam int UPW  = 2 * F + 3;
  localparam int PW   = QW + HW + 1;
  localparam int SQ_S = QW + 1;
  localparam int SR0  = QW + 2;
  localparam int UM_S = SR0 + F + 1;
  localparam int PR_S = UM_S + 1;
  localparam int OUT_S = PR_S + 1;
  localparam int NST  = OUT_S + 1;

  typedef struct packed {
    logic [RW-1:0] rem;
    logic [1:0]    lo;
    logic [QW-1:0] q;
    logic          neg;
  } div_ax_t;

  typedef struct packed {
    div_ax_t a;
    div_ax_t b;
    logic [PIX_W-1:0] pix;
  } div_t;

  typedef struct packed {
    logic [QW-1:0]   mag;
    logic            neg;
    logic [2*QW-1:0] sq;
  } sq_ax_t;

  typedef struct packed {
    sq_ax_t a;
    sq_ax_t b;
    logic [PIX_W-1:0] pix;
  } sq_t;

  typedef struct packed {
    logic [QW-1:0]  mag;
    logic           neg;
    logic [F:0]     rad;
    logic [F:0]     root;
    logic [SRW-1:0] rem;
  } sr_ax_t;

  typedef struct packed {
    sr_ax_t a;
    sr_ax_t b;
    logic [PIX_W-1:0] pix;
  } sr_t;

  typedef struct packed {
    logic [QW-1:0] um;
    logic          neg;
  } um_ax_t;

  typedef struct packed {
    um_ax_t a;
    um_ax_t b;
    logic [PIX_W-1:0] pix;
  } um_t;

  typedef struct packed {
    logic [PW-1:0] prod;
    logic          neg;
  } pr_ax_t;

  typedef struct packed {
    pr_ax_t a;
    pr_ax_t b;
    logic [PIX_W-1:0] pix;
  } pr_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [PIX_W-1:0] pix;
  } res_t;

  // --------------------------------------------------------------------------
  // helpers
  // --------------------------------------------------------------------------
  function automatic logic [HW-1:0] clamp_side(input logic [CFG_W-1:0] s);
    logic [HW-1:0] se;
    begin
      se = HW'(s);
      if (se < HW'(4))             clamp_side = HW'(4);
      else if (se > HW'(MAX_SIDE)) clamp_side = HW'(MAX_SIDE);
      else                         clamp_side = se;
    end
  endfunction

  function automatic div_ax_t norm_in(input logic [HW-1:0] pos, input logic [HW-1:0] side,
                                      input logic [HW-1:0] c);
    logic [HW-1:0] p;
    logic [HW-1:0] d;
    div_ax_t       y;
    begin
      p = (pos > side - HW'(1)) ? side - HW'(1) : pos;
      y.neg = (p < c);
      d = y.neg ? c - p : p - c;
      y.rem = RW'(d >> 2);
      y.lo  = d[1:0];
      y.q   = '0;
      norm_in = y;
    end
  endfunction

  // one quotient bit of (d << F) / c, bit j
  function automatic div_ax_t div_step(input div_ax_t x, input int j, input logic [HW-1:0] c);
    logic [QW-1:0] nd;
    logic [RW-1:0] t;
    div_ax_t       y;
    begin
      nd = {x.lo, F'(0)};
      y  = x;
      t  = {x.rem[RW-2:0], nd[j]};
      if (t >= RW'(c)) begin
        y.rem = t - RW'(c);
        y.q   = {x.q[QW-2:0], 1'b1};
      end else begin
        y.rem = t;
        y.q   = {x.q[QW-2:0], 1'b0};
      end
      div_step = y;
    end
  endfunction

  // rad = 1 - sq/2, floored at zero
  function automatic sr_ax_t sr_init(input sq_ax_t x);
    logic [2*QW-1:0] half;
    logic [2*QW-1:0] one;
    sr_ax_t          y;
    begin
      half   = x.sq >> (F + 1);
      one    = (2*QW)'(1) << F;
      y.mag  = x.mag;
      y.neg  = x.neg;
      y.rad  = (half >= one) ? '0 : (F+1)'(one - half);
      y.root = '0;
      y.rem  = '0;
      sr_init = y;
    end
  endfunction

  // one root bit of isqrt(rad << F), digit pair i
  function automatic sr_ax_t sr_step(input sr_ax_t x, input int i);
    logic [2*F+1:0] nn;
    logic [SRW-1:0] t;
    logic [SRW-1:0] tr;
    sr_ax_t         y;
    begin
      nn = {1'b0, x.rad, F'(0)};
      y  = x;
      t  = {x.rem[SRW-3:0], nn[2*i+1 -: 2]};
      tr = SRW'({x.root, 2'b01});
      if (t >= tr) begin
        y.rem  = t - tr;
        y.root = {x.root[F-1:0], 1'b1};
      end else begin
        y.rem  = t;
        y.root = {x.root[F-1:0], 1'b0};
      end
      sr_step = y;
    end
  endfunction

  function automatic um_ax_t scale_um(input logic [QW-1:0] mag, input logic neg,
                                      input logic [F:0] s);
    logic [UPW-1:0] p;
    um_ax_t         y;
    begin
      p     = UPW'(mag) * UPW'(s);
      y.um  = p[F+QW-1:F];
      y.neg = neg;
      scale_um = y;
    end
  endfunction

  function automatic logic [ROW_W-1:0] place(input pr_ax_t x, input logic [HW-1:0] c,
                                             input logic [HW-1:0] side);
    logic [PW-1:0] cf;
    logic [PW-1:0] p;
    begin
      cf = PW'(c) << F;
      if (x.neg) p = (x.prod > cf) ? '0 : ((cf - x.prod) >> F);
      else       p = (cf + x.prod) >> F;
      if (p > PW'(side - HW'(1))) p = PW'(side - HW'(1));
      place = p[ROW_W-1:0];
    end
  endfunction

  // --------------------------------------------------------------------------
  // configuration
  // --------------------------------------------------------------------------
  logic [CFG_W-1:0] height_r;
  logic [CFG_W-1:0] width_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      height_r <= RST_SIDE;
      width_r  <= RST_SIDE;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        CFG_IMAGE_HEIGHT: height_r <= cfg_wdata;
        CFG_IMAGE_WIDTH:  width_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic [HW-1:0] h_side;
  logic [HW-1:0] w_side;
  logic [HW-1:0] c_row;
  logic [HW-1:0] c_col;

  assign h_side = clamp_side(height_r);
  assign w_side = clamp_side(width_r);
  assign c_row  = (h_side >> 1) - HW'(1);
  assign c_col  = (w_side >> 1) - HW'(1);

  // --------------------------------------------------------------------------
  // stage flow control: a stage loads when empty or when its successor moves
  // --------------------------------------------------------------------------
  logic [NST-1:0] vld_r;
  logic [NST-1:0] vld_nxt;
  logic [NST:0]   rdy;

  assign rdy[NST] = out_tready;
  genvar g;
  generate
    for (g = 0; g < NST; g++) begin : g_rdy
      assign rdy[g] = ~vld_r[g] | rdy[g+1];
    end
  endgenerate

  assign vld_nxt   = {vld_r[NST-2:0], in_tvalid};
  assign in_tready = rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (rdy[k]) vld_r[k] <= vld_nxt[k];
      end
    end
  end

  // --------------------------------------------------------------------------
  // entry and divider
  // --------------------------------------------------------------------------
  div_t div_r [0:QW];

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      div_r[0].a   <= norm_in(HW'(in_tdata[ROW_LSB +: ROW_W]), h_side, c_row);
      div_r[0].b   <= norm_in(HW'(in_tdata[COL_LSB +: COL_W]), w_side, c_col);
      div_r[0].pix <= in_tdata[PIX_LSB +: PIX_W];
    end
  end

  generate
    for (g = 1; g <= QW; g++) begin : g_div
      always_ff @(posedge clk) begin
        if (rdy[g]) begin
          div_r[g].a   <= div_step(div_r[g-1].a, QW - g, c_row);
          div_r[g].b   <= div_step(div_r[g-1].b, QW - g, c_col);
          div_r[g].pix <= div_r[g-1].pix;
        end
      end
    end
  endgenerate

  // --------------------------------------------------------------------------
  // squares
  // --------------------------------------------------------------------------
  sq_t sq_r;

  always_ff @(posedge clk) begin
    if (rdy[SQ_S]) begin
      sq_r.a.mag <= div_r[QW].a.q;
      sq_r.a.neg <= div_r[QW].a.neg;
      sq_r.a.sq  <= (2*QW)'(div_r[QW].a.q) * (2*QW)'(div_r[QW].a.q);
      sq_r.b.mag <= div_r[QW].b.q;
      sq_r.b.neg <= div_r[QW].b.neg;
      sq_r.b.sq  <= (2*QW)'(div_r[QW].b.q) * (2*QW)'(div_r[QW].b.q);
      sq_r.pix   <= div_r[QW].pix;
    end
  end

  // --------------------------------------------------------------------------
  // square root, one bit per stage
  // --------------------------------------------------------------------------
  sr_t sr_in [0:F];
  sr_t sr_r  [0:F];

  assign sr_in[0].a   = sr_init(sq_r.a);
  assign sr_in[0].b   = sr_init(sq_r.b);
  assign sr_in[0].pix = sq_r.pix;

  generate
    for (g = 0; g <= F; g++) begin : g_sr
      if (g > 0) begin : g_link
        assign sr_in[g] = sr_r[g-1];
      end
      always_ff @(posedge clk) begin
        if (rdy[SR0+g]) begin
          sr_r[g].a   <= sr_step(sr_in[g].a, F - g);
          sr_r[g].b   <= sr_step(sr_in[g].b, F - g);
          sr_r[g].pix <= sr_in[g].pix;
        end
      end
    end
  endgenerate

  // --------------------------------------------------------------------------
  // scale back: row magnitude takes the column's root term and vice versa
  // --------------------------------------------------------------------------
  um_t  um_r;
  pr_t  pr_r;
  res_t out_r;

  always_ff @(posedge clk) begin
    if (rdy[UM_S]) begin
      um_r.a   <= scale_um(sr_r[F].a.mag, sr_r[F].a.neg, sr_r[F].b.root);
      um_r.b   <= scale_um(sr_r[F].b.mag, sr_r[F].b.neg, sr_r[F].a.root);
      um_r.pix <= sr_r[F].pix;
    end
    if (rdy[PR_S]) begin
      pr_r.a.prod <= PW'(um_r.a.um) * PW'(c_row);
      pr_r.a.neg  <= um_r.a.neg;
      pr_r.b.prod <= PW'(um_r.b.um) * PW'(c_col);
      pr_r.b.neg  <= um_r.b.neg;
      pr_r.pix    <= um_r.pix;
    end
    if (rdy[OUT_S]) begin
      out_r.row <= place(pr_r.a, c_row, h_side);
      out_r.col <= place(pr_r.b, c_col, w_side);
      out_r.pix <= pr_r.pix;
    end
  end

  assign out_tvalid = vld_r[OUT_S];
  assign out_tdata  = {PAD_W'(0), out_r.pix, out_r.col, out_r.row};

  // --------------------------------------------------------------------------
  // checks
  // --------------------------------------------------------------------------
  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (HW'(out_r.row) <= h_side - HW'(1)) || (h_side > HW'(1 << ROW_W)))
    else $error("dest_row beyond image height");

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (HW'(out_r.col) <= w_side - HW'(1)) || (w_side > HW'(1 << COL_W)))
    else $error("dest_col beyond image width");

  a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input blocked while output drains");

  a_root_max: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[SR0+F] |-> (sr_r[F].a.root <= (F+1)'(1) << F) && (sr_r[F].b.root <= (F+1)'(1) << F))
    else $error("root term above one");

endmodule

@@ tb/square_to_disc_pixel_warp_tb.sv @@
// ----------------------------------------------------------------------------
// square_to_disc_pixel_warp_tb
// Self-checking bench for the square-to-disc pixel warp. It streams source
// pixels under several image sizes, including clamped, odd and extreme ones.
// Both sides idle and stall at random. Each destination word is checked, field
// by field, against a fixed-point predictor of the elliptical grid mapping.
// ----------------------------------------------------------------------------
module square_to_disc_pixel_warp_tb;
  import sdw_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC     = 16;
  localparam int SIDE_MAX = 1024;
  localparam int LATENCY  = 2*FRAC + 8;
  localparam int WD_LIMIT = 5000;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } pixel_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [TDATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [TDATA_W-1:0] out_tdata;
  logic cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  pixel_t src_q[$];
  pixel_t dest_q[$];
  logic [CFG_W-1:0] height_reg = RST_SIDE;
  logic [CFG_W-1:0] width_reg = RST_SIDE;
  int errors = 0;
  int n_in = 0;
  int n_out = 0;
  int n_phases = 0;
  int idle_cnt = 0;
  bit no_gaps = 0;
  int in_gap = 0;
  int out_stall = 0;

  square_to_disc_pixel_warp u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint unsigned clamp_side(logic [CFG_W-1:0] s);
    if (s < 4) return 4;
    if (s > SIDE_MAX) return SIDE_MAX;
    return s;
  endfunction

  // sqrt(1 - m^2/2) in Q16, radicand floored at zero
  function automatic longint unsigned ellipse_root(longint unsigned m);
    longint unsigned one, half, rad;
    one = 64'd1 << FRAC;
    half = ((m * m) >> FRAC) >> 1;
    rad = (one > half) ? one - half : 0;
    return int_sqrt(rad << FRAC);
  endfunction

  function automatic longint unsigned disc_coord(longint unsigned m, bit neg,
      longint unsigned s, longint unsigned c, longint unsigned side);
    longint um, u, pf;
    longint unsigned p;
    um = longint'((m * s) >> FRAC);
    u = neg ? -um : um;
    pf = u * longint'(c) + longint'(c << FRAC);
    if (pf < 0) return 0;
    p = longint'(pf) >> FRAC;
    if (p > side - 1) p = side - 1;
    return p;
  endfunction

  function automatic pixel_t warp_predict(pixel_t px);
    longint unsigned h, w, ch, cw, r, c, xm, ym;
    bit xn, yn;
    pixel_t res;
    h = clamp_side(height_reg);
    w = clamp_side(width_reg);
    ch = h / 2 - 1;
    cw = w / 2 - 1;
    r = px.row;
    c = px.col;
    if (r > h - 1) r = h - 1;
    if (c > w - 1) c = w - 1;
    xn = r < ch;
    yn = c < cw;
    xm = ((xn ? ch - r : r - ch) << FRAC) / ch;
    ym = ((yn ? cw - c : c - cw) << FRAC) / cw;
    res.row = ROW_W'(disc_coord(xm, xn, ellipse_root(ym), ch, h));
    res.col = COL_W'(disc_coord(ym, yn, ellipse_root(xm), cw, w));
    res.pix = px.pix;
    return res;
  endfunction

  // mostly no gap or a short one, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (no_gaps || r < 11) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch word %0d: %s got %0d expected %0d", n_out, what, got, want);
    errors++;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_tvalid <= 1'b0;
      end else if (src_q.size() > 0) begin
        in_tdata <= {{PAD_W{1'b0}}, src_q.pop_front()};
        in_tvalid <= 1'b1;
        in_gap <= pick_gap();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // monitor and receiver stalls
  always @(posedge clk) begin
    pixel_t got, want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        dest_q.push_back(warp_predict(pixel_t'(in_tdata[PIX_LSB+PIX_W-1:0])));
        n_in++;
      end
      if (out_tvalid && out_tready) begin
        got = pixel_t'(out_tdata[PIX_LSB+PIX_W-1:0]);
        if (dest_q.size() == 0) begin
          $display("unexpected word %0d: %h", n_out, out_tdata);
          errors++;
        end else begin
          want = dest_q.pop_front();
          if (got.row !== want.row)
            report_mismatch("dest_row", int'(got.row), int'(want.row));
          if (got.col !== want.col)
            report_mismatch("dest_col", int'(got.col), int'(want.col));
          if (got.pix !== want.pix)
            report_mismatch("pixel_out", int'(got.pix), int'(want.pix));
        end
        n_out++;
      end
      if (out_stall > 0) begin
        out_stall <= out_stall - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        out_stall <= pick_gap();
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WD_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", WD_LIMIT);
      $display("square_to_disc_pixel_warp test failed");
      $finish;
    end
  end

  task automatic wait_drained();
    while (src_q.size() > 0 || in_tvalid || dest_q.size() > 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  // one write, then write enable dropped before return so back-to-back writes never collide
  task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_IMAGE_HEIGHT) height_reg = val;
    else width_reg = val;
    @(posedge clk);
  endtask

  task automatic queue_corners();
    int h, w;
    h = int'(clamp_side(height_reg));
    w = int'(clamp_side(width_reg));
    src_q.push_back('{pix: 8'd0, col: '0, row: '0});
    src_q.push_back('{pix: 8'd255, col: COL_W'(w-1), row: ROW_W'(h-1)});
    src_q.push_back('{pix: 8'h55, col: COL_W'(w-1), row: '0});
    src_q.push_back('{pix: 8'hAA, col: '0, row: ROW_W'(h-1)});
    src_q.push_back('{pix: 8'd1, col: COL_W'(w/2-1), row: ROW_W'(h/2-1)});
    src_q.push_back('{pix: 8'd128, col: COL_W'(w/2), row: ROW_W'(h/2)});
    // last row and column: beyond the image unless a side is 1024, clamped to the far edge
    src_q.push_back('{pix: 8'd77, col: '1, row: '1});
  endtask

  task automatic queue_random(int n);
    pixel_t px;
    int h, w;
    h = int'(clamp_side(height_reg));
    w = int'(clamp_side(width_reg));
    repeat (n) begin
      px.pix = PIX_W'($urandom_range(0, 255));
      if ($urandom_range(0, 9) < 8) begin
        px.row = ROW_W'($urandom_range(0, h-1));
        px.col = COL_W'($urandom_range(0, w-1));
      end else begin
        px.row = ROW_W'($urandom_range(0, 1023));
        px.col = COL_W'($urandom_range(0, 1023));
      end
      src_q.push_back(px);
    end
  endtask

  initial begin
    logic [CFG_W-1:0] sizes[9][2];
    sizes = '{'{11'd512, 11'd512}, '{11'd4, 11'd4}, '{11'd1024, 11'd1024},
              '{11'd0, 11'd2047}, '{11'd5, 11'd1023}, '{11'd1025, 11'd3},
              '{11'd17, 11'd640}, '{11'd300, 11'd7}, '{11'd999, 11'd999}};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // reset sizes first, then each written setting
    for (int p = 0; p < 9; p++) begin
      wait_drained();
      if (p > 0) begin
        write_reg(CFG_IMAGE_HEIGHT, sizes[p][0]);
        write_reg(CFG_IMAGE_WIDTH, sizes[p][1]);
      end
      n_phases++;
      no_gaps = (p % 3 == 2);
      queue_corners();
      queue_random(60);
      if (p == 4) begin
        // hold the sender until the pipe has emptied
        while (src_q.size() > 0 || in_tvalid || dest_q.size() > 0) @(posedge clk);
      end
      queue_random(60);
    end
    wait_drained();
    $display("%0d pixels in, %0d out, over %0d image size settings",
             n_in, n_out, n_phases);
    if (errors == 0) $display("square_to_disc_pixel_warp test passed");
    else $display("square_to_disc_pixel_warp test failed");
    $finish;
  end

endmodule
